[design/npts_pkg.sv]
// Package for the nearest point search block.
// Holds action, status and state codes and the fixed field widths.
// No dependencies.
package npts_pkg;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned DIST_W   = 50;
  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned POINT_W  = NUM_AXES * COORD_W;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_UNUSED = 2'd3
  } npts_action_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } npts_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } npts_state_t;

endpackage

[design/npts_ifs.sv]
// Channel interfaces for the nearest point search block.
// Depends on npts_pkg for the field widths.
interface npts_in_if
  import npts_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;

  modport source (output valid, action, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, action, coord_x, coord_y, coord_z, output ready);
endinterface

interface npts_out_if
  import npts_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] nearest_index;
  logic [DIST_W-1:0]  best_distance_sq;
  logic [1:0]         status;

  modport source (output valid, nearest_index, best_distance_sq, status, input ready);
  modport sink   (input valid, nearest_index, best_distance_sq, status, output ready);
endinterface

[design/npts_dist_cell.sv]
// One cell of the distance chain: adds the squared difference on one axis.
// Depends on npts_pkg.
module npts_dist_cell
  import npts_pkg::*;
#(
  parameter int unsigned AXIS = 0,
  parameter int unsigned IW   = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [IW-1:0]             in_idx,
  input  logic [POINT_W-1:0]        in_pt,
  input  logic [DIST_W-1:0]         in_sum,
  input  logic signed [COORD_W-1:0] q,
  output logic                      out_vld,
  output logic [IW-1:0]             out_idx,
  output logic [POINT_W-1:0]        out_pt,
  output logic [DIST_W-1:0]         out_sum
);

  localparam int unsigned LSB = (NUM_AXES - 1 - AXIS) * COORD_W;

  logic signed [COORD_W-1:0] a;
  logic signed [COORD_W:0]   diff;
  logic [COORD_W-1:0]        mag;
  logic [2*COORD_W-1:0]      sq;

  logic                      vld_r;
  logic [IW-1:0]             idx_r;
  logic [POINT_W-1:0]        pt_r;
  logic [DIST_W-1:0]         sum_r;

  always_comb begin
    a    = in_pt[LSB +: COORD_W];
    diff = {a[COORD_W-1], a} - {q[COORD_W-1], q};
    mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
    sq   = mag * mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    idx_r <= in_idx;
    pt_r  <= in_pt;
    sum_r <= in_sum + DIST_W'(sq);
  end

  assign out_vld = vld_r;
  assign out_idx = idx_r;
  assign out_pt  = pt_r;
  assign out_sum = sum_r;

endmodule

[design/nearest_point_search_top.sv]
// Top level of the nearest point search block.
// Depends on npts_pkg, npts_ifs and npts_dist_cell.
//
// The block keeps a table of 3-D points and takes one command beat at a time
// on in_ch: clear the table, append a point, or query with a point. Every
// command beat produces exactly one result beat on out_ch carrying the index
// of the nearest stored point, its squared distance and a status code.
// A clear, an append or an unused action passes through the exec and finish
// states into the output register; in_ch is ready again as that load is made.
// A query reads the table once, one entry per cycle through the single read
// port of the point memory, and each entry passes through a chain of three
// distance cells (one per axis) before the running minimum; its result goes
// through the pending result register into the output register. Ties keep the
// lower index because entries are scanned in index order with a strict compare.
// During reset in_ch is held not ready and the table comes out empty; the
// memory contents are not cleared, since only entries below the fill count
// are read. The result sits in an output register, so the next command beat is
// accepted while a finished result still waits on out_ch. If the receiver
// stalls and a second result is ready, the block holds it in its finish state
// and accepts no more beats until the output register frees up.
module nearest_point_search_top
  import npts_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input logic   clk,
  input logic   rst_n,
  npts_in_if.sink    in_ch,
  npts_out_if.source out_ch
);

  localparam int unsigned AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned NCELL = NUM_AXES;

  npts_state_t state_r, state_nxt;

  npts_action_t              act_r;
  logic signed [COORD_W-1:0] qx_r, qy_r, qz_r;
  logic [CW-1:0]             count_r;
  logic [AW-1:0]             scan_r;

  // Point memory and its registered read port.
  logic [POINT_W-1:0] mem [MAX_POINTS];
  logic [POINT_W-1:0] rd_data_r;
  logic               rd_vld_r;
  logic [AW-1:0]      rd_idx_r;

  // Distance chain taps.
  logic                      vld_s [NCELL+1];
  logic [AW-1:0]             idx_s [NCELL+1];
  logic [DIST_W-1:0]         sum_s [NCELL+1];
  logic [POINT_W-1:0]        pt_s  [NCELL];
  logic signed [COORD_W-1:0] q_s   [NCELL];

  // Running minimum.
  logic              have_r;
  logic [DIST_W-1:0] best_r;
  logic [AW-1:0]     best_idx_r;

  // Pending result and output register.
  logic [INDEX_W-1:0] res_idx_r;
  logic [DIST_W-1:0]  res_dist_r;
  npts_status_t       res_sts_r;
  logic               out_vld_r;
  logic [INDEX_W-1:0] out_idx_r;
  logic [DIST_W-1:0]  out_dist_r;
  npts_status_t       out_sts_r;

  logic full, last_issue, busy;
  logic accept, rd_en, wr_en, load_out, drain_done;

  assign full       = (count_r == CW'(MAX_POINTS));
  assign last_issue = (CW'(scan_r) == count_r - 1'b1);
  assign busy       = rd_vld_r | vld_s[1] | vld_s[2] | vld_s[3];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (act_r == ACT_QUERY && count_r != '0) state_nxt = ST_SCAN;
        else state_nxt = ST_FINISH;
      end
      ST_SCAN:   if (last_issue) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (!busy) state_nxt = ST_FINISH;
      ST_FINISH: if (!out_vld_r || out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    accept     = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    load_out   = 1'b0;
    drain_done = 1'b0;
    unique case (state_r)
      ST_IDLE:   accept = in_ch.valid;
      ST_EXEC:   wr_en = (act_r == ACT_APPEND) && !full;
      ST_SCAN:   rd_en = 1'b1;
      ST_DRAIN:  drain_done = !busy;
      ST_FINISH: load_out = !out_vld_r || out_ch.ready;
      default: ;
    endcase
  end

  assign in_ch.ready = rst_n && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EXEC) begin
        if (act_r == ACT_CLEAR) count_r <= '0;
        else if (wr_en) count_r <= count_r + 1'b1;
      end
    end
  end

  // Command capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= npts_action_t'(in_ch.action);
      qx_r  <= in_ch.coord_x;
      qy_r  <= in_ch.coord_y;
      qz_r  <= in_ch.coord_z;
    end
  end

  // Scan address counter.
  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) scan_r <= '0;
    else if (rd_en) scan_r <= scan_r + 1'b1;
  end

  // Point memory.
  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[AW-1:0]] <= {qx_r, qy_r, qz_r};
    if (rd_en) rd_data_r <= mem[scan_r];
    rd_idx_r <= scan_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else rd_vld_r <= rd_en;
  end

  // Chain of distance cells, one axis each.
  assign vld_s[0] = rd_vld_r;
  assign idx_s[0] = rd_idx_r;
  assign sum_s[0] = '0;
  assign pt_s[0]  = rd_data_r;
  assign q_s[0]   = qx_r;
  assign q_s[1]   = qy_r;
  assign q_s[2]   = qz_r;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    if (k < NCELL - 1) begin : g_mid
      npts_dist_cell #(.AXIS(k), .IW(AW)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (vld_s[k]),
        .in_idx  (idx_s[k]),
        .in_pt   (pt_s[k]),
        .in_sum  (sum_s[k]),
        .q       (q_s[k]),
        .out_vld (vld_s[k+1]),
        .out_idx (idx_s[k+1]),
        .out_pt  (pt_s[k+1]),
        .out_sum (sum_s[k+1])
      );
    end else begin : g_last
      npts_dist_cell #(.AXIS(k), .IW(AW)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (vld_s[k]),
        .in_idx  (idx_s[k]),
        .in_pt   (pt_s[k]),
        .in_sum  (sum_s[k]),
        .q       (q_s[k]),
        .out_vld (vld_s[k+1]),
        .out_idx (idx_s[k+1]),
        .out_pt  (),
        .out_sum (sum_s[k+1])
      );
    end
  end

  // Running minimum; a strict compare keeps the lower index on a tie.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (state_r == ST_EXEC) begin
      have_r <= 1'b0;
    end else if (vld_s[NCELL]) begin
      have_r <= 1'b1;
    end
    if (vld_s[NCELL] && (!have_r || sum_s[NCELL] < best_r)) begin
      best_r     <= sum_s[NCELL];
      best_idx_r <= idx_s[NCELL];
    end
  end

  // Pending result.
  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      res_idx_r  <= '0;
      res_dist_r <= '0;
      res_sts_r  <= STS_OK;
      if (act_r == ACT_APPEND && full) res_sts_r <= STS_FULL;
      if (act_r == ACT_QUERY && count_r == '0) res_sts_r <= STS_EMPTY;
    end else if (drain_done) begin
      res_idx_r  <= INDEX_W'(best_idx_r);
      res_dist_r <= best_r;
      res_sts_r  <= STS_OK;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
    if (load_out) begin
      out_idx_r  <= res_idx_r;
      out_dist_r <= res_dist_r;
      out_sts_r  <= res_sts_r;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.nearest_index    = out_idx_r;
  assign out_ch.best_distance_sq = out_dist_r;
  assign out_ch.status           = out_sts_r;

  // The scan only reads entries that have been written.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (CW'(scan_r) < count_r))
    else $error("scan address beyond fill count");

  // The fill count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("fill count above table size");

  // A finished query scan has seen at least one point.
  a_query_found: assert property (@(posedge clk) disable iff (!rst_n)
    drain_done |-> have_r)
    else $error("query finished without a candidate");

endmodule

[tb/npts_result_checker.sv]
// Passive checker for the nearest point search block.
// Watches both channels, predicts each result and compares it field by field.
// Depends on npts_pkg and the channel interfaces in npts_ifs.
module npts_result_checker
  import npts_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic clk,
  input  logic rst_n,
  npts_in_if   in_ch,
  npts_out_if  out_ch,
  output int   fail_count,
  output int   pending_count
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  typedef struct packed {
    logic [INDEX_W-1:0] nearest_index;
    logic [DIST_W-1:0]  best_distance_sq;
    logic [1:0]         status;
  } search_result_t;

  logic signed [COORD_W-1:0] table_x [MAX_POINTS];
  logic signed [COORD_W-1:0] table_y [MAX_POINTS];
  logic signed [COORD_W-1:0] table_z [MAX_POINTS];
  int unsigned               fill_count;
  search_result_t            expected_q[$];

  function automatic longint unsigned axis_sq(logic signed [COORD_W-1:0] a,
                                              logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return longint'(d * d);
  endfunction

  // Applies one command to the shadow table and returns what the block owes.
  function automatic search_result_t run_command(logic [1:0] act,
                                                 logic signed [COORD_W-1:0] px,
                                                 logic signed [COORD_W-1:0] py,
                                                 logic signed [COORD_W-1:0] pz);
    search_result_t    r;
    longint unsigned   d;
    longint unsigned   best;
    r = '0;
    best = 0;
    case (act)
      ACT_CLEAR: fill_count = 0;
      ACT_APPEND: begin
        if (fill_count >= MAX_POINTS) begin
          r.status = STS_FULL;
        end else begin
          table_x[fill_count[AW-1:0]] = px;
          table_y[fill_count[AW-1:0]] = py;
          table_z[fill_count[AW-1:0]] = pz;
          fill_count++;
        end
      end
      ACT_QUERY: begin
        if (fill_count == 0) begin
          r.status = STS_EMPTY;
        end else begin
          for (int unsigned j = 0; j < fill_count; j++) begin
            d = axis_sq(table_x[j[AW-1:0]], px) + axis_sq(table_y[j[AW-1:0]], py)
                + axis_sq(table_z[j[AW-1:0]], pz);
            // Strict compare, so the lower index wins a tie.
            if (j == 0 || d < best) begin
              best = d;
              r.nearest_index = j[INDEX_W-1:0];
            end
          end
          r.best_distance_sq = best[DIST_W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    search_result_t want;
    if (!rst_n) begin
      fill_count = 0;
      expected_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_q.insert(expected_q.size(),
                          run_command(in_ch.action, in_ch.coord_x, in_ch.coord_y,
                                      in_ch.coord_z));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected result beat idx=%0d dist=%0d status=%0d",
                     out_ch.nearest_index, out_ch.best_distance_sq, out_ch.status);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.nearest_index !== want.nearest_index ||
              out_ch.best_distance_sq !== want.best_distance_sq ||
              out_ch.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"ERROR: expected idx=%0d dist=%0d status=%0d, ",
                        "got idx=%0d dist=%0d status=%0d"},
                       want.nearest_index, want.best_distance_sq, want.status,
                       out_ch.nearest_index, out_ch.best_distance_sq, out_ch.status);
          end
        end
      end
    end
    pending_count = expected_q.size();
  end

endmodule

[tb/tb_nearest_point_search_top.sv]
// Testbench top for the nearest point search block.
// Drives commands and result back-pressure; npts_result_checker does the checking.
// Depends on npts_pkg, npts_ifs, nearest_point_search_top and npts_result_checker.
module tb_nearest_point_search_top;
  import npts_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1024;
  // Tables stay below about sixty points, so a query finishes quickly, and the
  // long receiver hold-off is bounded; this limit leaves a wide margin over both.
  localparam int unsigned STALL_LIMIT = 8000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;

  // Set by the command process; the receiver process reads them.
  bit   quiet_phase;
  bit   long_hold_req;

  npts_in_if  in_ch ();
  npts_out_if out_ch ();

  nearest_point_search_top #(.MAX_POINTS(TABLE_DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  npts_result_checker #(.MAX_POINTS(TABLE_DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: ends the run if no beat moves on either channel for too long.
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver side. It stalls in short random bursts, once holds off for a
  // long stretch so the block backs up into its input, and stops stalling
  // entirely in the quiet phase at the end of the run.
  initial begin
    bit hold_seen;
    hold_seen = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (150) @(posedge clk);
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one command beat and returns at the edge where it is taken. A
  // random gap may come first; otherwise valid stays high across beats.
  task automatic send_cmd(input logic [1:0] act, input logic signed [COORD_W-1:0] x,
                          input logic signed [COORD_W-1:0] y,
                          input logic signed [COORD_W-1:0] z);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    in_ch.coord_z <= z;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Coordinates come from three pools: the full range, a tiny cluster around
  // zero that makes equal distances common, and the extremes of the field.
  function automatic logic signed [COORD_W-1:0] pick_coord(int unsigned pool);
    logic signed [COORD_W-1:0] c;
    case (pool)
      0: c = COORD_W'($urandom);
      1: c = COORD_W'($signed($urandom_range(0, 6)) - 3);
      default: begin
        case ($urandom_range(0, 3))
          0: c = {1'b1, {(COORD_W-1){1'b0}}};
          1: c = {1'b0, {(COORD_W-1){1'b1}}};
          2: c = '0;
          default: c = '1;
        endcase
      end
    endcase
    return c;
  endfunction

  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  initial begin
    int unsigned sent;
    int unsigned shadow_fill;
    int unsigned n;
    int unsigned pool;
    bit          hold_done;
    bit          pause_done;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= ACT_CLEAR;
    in_ch.coord_x <= '0;
    in_ch.coord_y <= '0;
    in_ch.coord_z <= '0;
    quiet_phase   = 1'b0;
    long_hold_req = 1'b0;
    sent          = 0;
    shadow_fill   = 0;
    hold_done     = 1'b0;
    pause_done    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty query, field extremes with the largest possible
    // distance, an exact hit, the unused action code and a distance tie.
    send_cmd(ACT_QUERY, '0, '0, '0);
    send_cmd(ACT_APPEND, C_MAX, C_MAX, C_MAX);
    send_cmd(ACT_APPEND, C_MIN, C_MIN, C_MIN);
    send_cmd(ACT_QUERY, '0, '0, '0);
    send_cmd(ACT_QUERY, C_MAX, C_MAX, C_MAX);
    send_cmd(ACT_QUERY, C_MIN, C_MIN, C_MIN);
    send_cmd(ACT_UNUSED, C_MIN, C_MAX, COORD_W'(-1));
    send_cmd(ACT_QUERY, COORD_W'(-1), COORD_W'(-1), COORD_W'(-1));
    send_cmd(ACT_CLEAR, C_MAX, C_MIN, '0);
    send_cmd(ACT_QUERY, COORD_W'(5), COORD_W'(5), COORD_W'(5));
    send_cmd(ACT_APPEND, C_MIN, C_MIN, C_MIN);
    send_cmd(ACT_QUERY, C_MAX, C_MAX, C_MAX);
    send_cmd(ACT_CLEAR, '0, '0, '0);
    send_cmd(ACT_APPEND, COORD_W'(1), '0, '0);
    send_cmd(ACT_APPEND, COORD_W'(-1), '0, '0);
    send_cmd(ACT_APPEND, '0, COORD_W'(1), '0);
    send_cmd(ACT_QUERY, '0, '0, '0);
    send_cmd(ACT_QUERY, '0, '0, COORD_W'(7));
    send_cmd(ACT_QUERY, COORD_W'(-9), '0, '0);
    send_cmd(ACT_CLEAR, '0, '0, '0);

    // Random part, mostly well-formed runs of appends followed by queries,
    // with clears, empty queries and unused actions mixed in as noise.
    while (sent < 560) begin
      if (sent >= 470)
        quiet_phase = 1'b1;

      if (!hold_done && sent >= 150) begin
        hold_done     = 1'b1;
        long_hold_req = 1'b1;
      end

      if (!pause_done && sent >= 300) begin
        pause_done = 1'b1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
      end

      case ($urandom_range(0, 9))
        0: begin
          send_cmd(ACT_CLEAR, pick_coord(0), pick_coord(0), pick_coord(0));
          shadow_fill = 0;
          sent++;
        end
        1: begin
          send_cmd(ACT_UNUSED, pick_coord(0), pick_coord(0), pick_coord(0));
          sent++;
        end
        2: begin
          send_cmd(ACT_QUERY, pick_coord(0), pick_coord(1), pick_coord(2));
          sent++;
        end
        default: begin
          // Keep tables small so queries stay short.
          if (shadow_fill > 40) begin
            send_cmd(ACT_CLEAR, '0, '0, '0);
            shadow_fill = 0;
            sent++;
          end
          pool = $urandom_range(0, 2);
          n = $urandom_range(1, 12);
          for (int unsigned i = 0; i < n; i++) begin
            send_cmd(ACT_APPEND, pick_coord(pool), pick_coord(pool),
                     pick_coord($urandom_range(0, 2)));
            shadow_fill++;
            sent++;
          end
          n = $urandom_range(1, 4);
          for (int unsigned i = 0; i < n; i++) begin
            send_cmd(ACT_QUERY, pick_coord(pool), pick_coord($urandom_range(0, 2)),
                     pick_coord(pool));
            sent++;
          end
        end
      endcase
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
